// ----- src/glpf_pkg.sv -----
// glpf_pkg: shared constants, register indexes, sequencer codes and ring-slot
// helpers for the grid local peak finder. No dependencies.
package glpf_pkg;

    // Configuration port layout
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [CFG_W-1:0]     GRID_SIZE_RESET = 5'd16;

    // Width of the reported row and column
    localparam int POS_OUT_W = 4;

    // Row store is a ring of three rows
    localparam int SLOT_W = 2;
    localparam logic [SLOT_W-1:0] SLOT_FIRST = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 2'd2;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_EVAL,
        BK_DONE
    } t_back_state;

    // Read phases of one decision: address issued in a phase, data in the next
    typedef enum logic [2:0] {
        RD_CTR,
        RD_UP,
        RD_LEFT,
        RD_RIGHT,
        RD_WAIT
    } t_rd_phase;

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
        slot_next = (s == SLOT_LAST) ? SLOT_FIRST : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
        slot_prev = (s == SLOT_FIRST) ? SLOT_LAST : s - 1'b1;
    endfunction

endpackage

// ----- src/glpf_pixel_if.sv -----
// glpf_pixel_if: valid/ready channel carrying one signed pixel per word.
// Depends on nothing.
interface glpf_pixel_if #(
    parameter int PIXEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_value;

    modport source (output valid, output pixel_value, input ready);
    modport sink   (input valid, input pixel_value, output ready);
endinterface

// ----- src/glpf_peak_if.sv -----
// glpf_peak_if: valid/ready channel carrying one peak position per word.
// Depends on nothing.
interface glpf_peak_if;
    logic       valid;
    logic       ready;
    logic [3:0] peak_row;
    logic [3:0] peak_col;
    logic       last_of_run;

    modport source (output valid, output peak_row, output peak_col, output last_of_run,
                    input ready);
    modport sink   (input valid, input peak_row, input peak_col, input last_of_run,
                    output ready);
endinterface

// ----- src/glpf_ram.sv -----
// glpf_ram: generic simple dual-port RAM, one write port, one registered read port.
// Depends on nothing.
module glpf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/glpf_cmd_fifo.sv -----
// glpf_cmd_fifo: short queue of decision commands between front and back end.
// Depends on nothing.
module glpf_cmd_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_buf [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_buf[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Hold entries
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end
endmodule

// ----- src/glpf_front.sv -----
// glpf_front: accepts pixels, tracks raster position and grid size, writes the
// row store and queues one decision command per pixel. Uses glpf_pkg, glpf_pixel_if.
module glpf_front #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int PIXEL_BITS = 16,
    parameter int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int CSZ_W      = $clog2(MAX_COLS + 1),
    parameter int ADDR_W     = $clog2(3 * MAX_COLS),
    parameter int CMD_W      = ROW_W + COL_W + glpf_pkg::SLOT_W + PIXEL_BITS + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [glpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [glpf_pkg::CFG_W-1:0]     i_cfg_wdata,
    glpf_pixel_if.sink                     pix,
    input  logic                           i_busy,
    input  logic                           i_q_full,
    output logic                           o_q_push,
    output logic [CMD_W-1:0]               o_q_cmd,
    output logic                           o_ram_we,
    output logic [ADDR_W-1:0]              o_ram_waddr,
    output logic [PIXEL_BITS-1:0]          o_ram_wdata,
    output logic [CSZ_W-1:0]               o_cols_eff
);
    localparam int RSZ_W = $clog2(MAX_ROWS + 1);

    typedef struct packed {
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic [glpf_pkg::SLOT_W-1:0] slot;
        logic [PIXEL_BITS-1:0]       value;
        logic                        frame_end;
    } t_cmd;

    logic [glpf_pkg::CFG_W-1:0]  r_grid_rows, n_grid_rows;
    logic [glpf_pkg::CFG_W-1:0]  r_grid_cols, n_grid_cols;
    logic [ROW_W-1:0]            r_cur_row, n_cur_row;
    logic [COL_W-1:0]            r_cur_col, n_cur_col;
    logic [glpf_pkg::SLOT_W-1:0] r_cur_slot, n_cur_slot;
    logic [ROW_W-1:0]            r_last_row, n_last_row;
    logic                        r_last_flush, n_last_flush;

    logic [RSZ_W-1:0] w_rows_eff;
    logic [CSZ_W-1:0] w_cols_eff;
    logic             w_row_last, w_col_last, w_frame_end;
    logic             w_ready, w_accept;
    t_cmd             w_cmd;

    // Clamp grid size to 1..MAX
    always_comb begin
        if (r_grid_rows == '0) begin
            w_rows_eff = RSZ_W'(1);
        end else if (int'(r_grid_rows) > MAX_ROWS) begin
            w_rows_eff = RSZ_W'(MAX_ROWS);
        end else begin
            w_rows_eff = RSZ_W'(r_grid_rows);
        end
        if (r_grid_cols == '0) begin
            w_cols_eff = CSZ_W'(1);
        end else if (int'(r_grid_cols) > MAX_COLS) begin
            w_cols_eff = CSZ_W'(MAX_COLS);
        end else begin
            w_cols_eff = CSZ_W'(r_grid_cols);
        end
    end

    assign w_row_last  = ((RSZ_W'(r_cur_row) + 1'b1) == w_rows_eff);
    assign w_col_last  = ((CSZ_W'(r_cur_col) + 1'b1) == w_cols_eff);
    assign w_frame_end = w_row_last && w_col_last;

    // Stall on a row change or after a frame end until the back end drains,
    // so the ring slot being written is never one still under decision
    assign w_ready  = !i_q_full && (!i_busy || (r_cur_row == r_last_row && !r_last_flush));
    assign w_accept = pix.valid && w_ready;
    assign pix.ready = w_ready;

    assign w_cmd.row       = r_cur_row;
    assign w_cmd.col       = r_cur_col;
    assign w_cmd.slot      = r_cur_slot;
    assign w_cmd.value     = pix.pixel_value;
    assign w_cmd.frame_end = w_frame_end;

    assign o_q_push    = w_accept;
    assign o_q_cmd     = w_cmd;
    assign o_ram_we    = w_accept;
    assign o_ram_waddr = ADDR_W'(r_cur_slot) * ADDR_W'(MAX_COLS) + ADDR_W'(r_cur_col);
    assign o_ram_wdata = pix.pixel_value;
    assign o_cols_eff  = w_cols_eff;

    // Configuration writes and raster advance
    always_comb begin
        n_grid_rows  = r_grid_rows;
        n_grid_cols  = r_grid_cols;
        n_cur_row    = r_cur_row;
        n_cur_col    = r_cur_col;
        n_cur_slot   = r_cur_slot;
        n_last_row   = r_last_row;
        n_last_flush = r_last_flush;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                glpf_pkg::REG_GRID_ROWS: begin
                    n_grid_rows = i_cfg_wdata;
                    n_cur_row   = '0;
                    n_cur_col   = '0;
                    n_cur_slot  = glpf_pkg::SLOT_FIRST;
                end
                glpf_pkg::REG_GRID_COLS: begin
                    n_grid_cols = i_cfg_wdata;
                    n_cur_row   = '0;
                    n_cur_col   = '0;
                    n_cur_slot  = glpf_pkg::SLOT_FIRST;
                end
                default: begin
                end
            endcase
        end else if (w_accept) begin
            n_last_row   = r_cur_row;
            n_last_flush = w_frame_end;
            if (w_frame_end) begin
                n_cur_row  = '0;
                n_cur_col  = '0;
                n_cur_slot = glpf_pkg::SLOT_FIRST;
            end else if (w_col_last) begin
                n_cur_row  = r_cur_row + 1'b1;
                n_cur_col  = '0;
                n_cur_slot = glpf_pkg::slot_next(r_cur_slot);
            end else begin
                n_cur_col = r_cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= glpf_pkg::GRID_SIZE_RESET;
            r_grid_cols  <= glpf_pkg::GRID_SIZE_RESET;
            r_cur_row    <= '0;
            r_cur_col    <= '0;
            r_cur_slot   <= glpf_pkg::SLOT_FIRST;
            r_last_row   <= '0;
            r_last_flush <= 1'b0;
        end else begin
            r_grid_rows  <= n_grid_rows;
            r_grid_cols  <= n_grid_cols;
            r_cur_row    <= n_cur_row;
            r_cur_col    <= n_cur_col;
            r_cur_slot   <= n_cur_slot;
            r_last_row   <= n_last_row;
            r_last_flush <= n_last_flush;
        end
    end
endmodule

// ----- src/glpf_back.sv -----
// glpf_back: pops decision commands, reads neighbours from the row store one
// per cycle, compares and emits peak words. Uses glpf_pkg, glpf_peak_if.
module glpf_back #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int PIXEL_BITS = 16,
    parameter int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    parameter int CSZ_W      = $clog2(MAX_COLS + 1),
    parameter int ADDR_W     = $clog2(3 * MAX_COLS),
    parameter int CMD_W      = ROW_W + COL_W + glpf_pkg::SLOT_W + PIXEL_BITS + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  logic [CMD_W-1:0]      i_q_cmd,
    output logic                  o_q_pop,
    input  logic [CSZ_W-1:0]      i_cols_eff,
    output logic [ADDR_W-1:0]     o_ram_raddr,
    input  logic [PIXEL_BITS-1:0] i_ram_rdata,
    output logic                  o_busy,
    glpf_peak_if.source           peak
);
    localparam int OW = glpf_pkg::POS_OUT_W;

    typedef struct packed {
        logic [ROW_W-1:0]            row;
        logic [COL_W-1:0]            col;
        logic [glpf_pkg::SLOT_W-1:0] slot;
        logic [PIXEL_BITS-1:0]       value;
        logic                        frame_end;
    } t_cmd;

    glpf_pkg::t_back_state r_state, n_state;
    glpf_pkg::t_rd_phase   r_phase, n_phase;
    t_cmd                  r_cmd, n_cmd;
    t_cmd                  w_qc;
    logic                  r_in_flush, n_in_flush;
    logic [glpf_pkg::SLOT_W-1:0] r_dec_slot, n_dec_slot;
    logic [ROW_W-1:0]      r_dec_row, n_dec_row;
    logic [COL_W-1:0]      r_dec_col, n_dec_col;
    logic                  r_up_ok, n_up_ok;
    logic                  r_down_ok, n_down_ok;
    logic signed [PIXEL_BITS-1:0] r_down, n_down;
    logic signed [PIXEL_BITS-1:0] r_ctr, n_ctr;
    logic signed [PIXEL_BITS-1:0] r_up, n_up;
    logic signed [PIXEL_BITS-1:0] r_left, n_left;
    logic signed [PIXEL_BITS-1:0] r_right, n_right;
    logic                  r_hold_valid, n_hold_valid;
    logic [OW-1:0]         r_hold_row, n_hold_row;
    logic [OW-1:0]         r_hold_col, n_hold_col;
    logic                  r_out_valid, n_out_valid;
    logic [OW-1:0]         r_out_row, n_out_row;
    logic [OW-1:0]         r_out_col, n_out_col;
    logic                  r_out_last, n_out_last;

    logic w_left_ok, w_right_ok, w_peak, w_out_free, w_pop;
    logic [COL_W-1:0] w_rd_col;
    logic [glpf_pkg::SLOT_W-1:0] w_rd_slot;

    assign w_qc       = i_q_cmd;
    assign w_left_ok  = (r_dec_col != '0);
    assign w_right_ok = ((CSZ_W'(r_dec_col) + 1'b1) < i_cols_eff);
    assign w_out_free = !r_out_valid || peak.ready;
    assign w_peak     = (!r_up_ok    || r_ctr >= r_up)
                     && (!r_down_ok  || r_ctr >= r_down)
                     && (!w_left_ok  || r_ctr >= r_left)
                     && (!w_right_ok || r_ctr >= r_right);

    // Pick the neighbour to read in this phase
    always_comb begin
        w_rd_slot = r_dec_slot;
        w_rd_col  = r_dec_col;
        case (r_phase)
            glpf_pkg::RD_UP:    w_rd_slot = glpf_pkg::slot_prev(r_dec_slot);
            glpf_pkg::RD_LEFT:  w_rd_col  = r_dec_col - 1'b1;
            glpf_pkg::RD_RIGHT: w_rd_col  = r_dec_col + 1'b1;
            default: begin
            end
        endcase
    end

    assign o_ram_raddr = ADDR_W'(w_rd_slot) * ADDR_W'(MAX_COLS) + ADDR_W'(w_rd_col);
    assign o_q_pop     = w_pop;
    assign o_busy      = (r_state != glpf_pkg::BK_IDLE);

    assign peak.valid       = r_out_valid;
    assign peak.peak_row    = r_out_row;
    assign peak.peak_col    = r_out_col;
    assign peak.last_of_run = r_out_last;

    // Sequencer: next state and datapath loads
    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_cmd        = r_cmd;
        n_in_flush   = r_in_flush;
        n_dec_slot   = r_dec_slot;
        n_dec_row    = r_dec_row;
        n_dec_col    = r_dec_col;
        n_up_ok      = r_up_ok;
        n_down_ok    = r_down_ok;
        n_down       = r_down;
        n_ctr        = r_ctr;
        n_up         = r_up;
        n_left       = r_left;
        n_right      = r_right;
        n_hold_valid = r_hold_valid;
        n_hold_row   = r_hold_row;
        n_hold_col   = r_hold_col;
        n_out_valid  = r_out_valid && !peak.ready;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;
        w_pop        = 1'b0;

        case (r_state)
            glpf_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    w_pop      = 1'b1;
                    n_cmd      = w_qc;
                    n_phase    = glpf_pkg::RD_CTR;
                    n_in_flush = 1'b0;
                    if (w_qc.row != '0) begin
                        // Decide the pixel just above
                        n_dec_slot = glpf_pkg::slot_prev(w_qc.slot);
                        n_dec_row  = w_qc.row - 1'b1;
                        n_dec_col  = w_qc.col;
                        n_up_ok    = (w_qc.row > ROW_W'(1));
                        n_down_ok  = 1'b1;
                        n_down     = $signed(w_qc.value);
                        n_state    = glpf_pkg::BK_READ;
                    end else if (w_qc.frame_end) begin
                        // Single-row grid: go straight to the flush
                        n_dec_slot = w_qc.slot;
                        n_dec_row  = w_qc.row;
                        n_dec_col  = '0;
                        n_up_ok    = 1'b0;
                        n_down_ok  = 1'b0;
                        n_in_flush = 1'b1;
                        n_state    = glpf_pkg::BK_READ;
                    end
                end
            end

            glpf_pkg::BK_READ: begin
                // Capture the word addressed in the previous phase
                case (r_phase)
                    glpf_pkg::RD_CTR: begin
                        n_phase = glpf_pkg::RD_UP;
                    end
                    glpf_pkg::RD_UP: begin
                        n_ctr   = $signed(i_ram_rdata);
                        n_phase = glpf_pkg::RD_LEFT;
                    end
                    glpf_pkg::RD_LEFT: begin
                        n_up    = $signed(i_ram_rdata);
                        n_phase = glpf_pkg::RD_RIGHT;
                    end
                    glpf_pkg::RD_RIGHT: begin
                        n_left  = $signed(i_ram_rdata);
                        n_phase = glpf_pkg::RD_WAIT;
                    end
                    default: begin
                        n_right = $signed(i_ram_rdata);
                        n_phase = glpf_pkg::RD_CTR;
                        n_state = glpf_pkg::BK_EVAL;
                    end
                endcase
            end

            glpf_pkg::BK_EVAL: begin
                if (!w_peak || !r_hold_valid || w_out_free) begin
                    if (w_peak) begin
                        // Release the held peak, hold the new one
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out_row   = r_hold_row;
                            n_out_col   = r_hold_col;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold_row   = OW'(r_dec_row);
                        n_hold_col   = OW'(r_dec_col);
                    end
                    n_phase = glpf_pkg::RD_CTR;
                    if (!r_in_flush && r_cmd.frame_end) begin
                        n_dec_slot = r_cmd.slot;
                        n_dec_row  = r_cmd.row;
                        n_dec_col  = '0;
                        n_up_ok    = (r_cmd.row != '0);
                        n_down_ok  = 1'b0;
                        n_in_flush = 1'b1;
                        n_state    = glpf_pkg::BK_READ;
                    end else if (r_in_flush && w_right_ok) begin
                        n_dec_col = r_dec_col + 1'b1;
                        n_state   = glpf_pkg::BK_READ;
                    end else begin
                        n_state = glpf_pkg::BK_DONE;
                    end
                end
            end

            glpf_pkg::BK_DONE: begin
                // Flush the held peak as the last word of the run
                if (!r_hold_valid) begin
                    n_state = glpf_pkg::BK_IDLE;
                end else if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_row    = r_hold_row;
                    n_out_col    = r_hold_col;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = glpf_pkg::BK_IDLE;
                end
            end

            default: begin
                n_state = glpf_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= glpf_pkg::BK_IDLE;
            r_phase      <= glpf_pkg::RD_CTR;
            r_in_flush   <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_phase      <= n_phase;
            r_in_flush   <= n_in_flush;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_dec_slot <= n_dec_slot;
        r_dec_row  <= n_dec_row;
        r_dec_col  <= n_dec_col;
        r_up_ok    <= n_up_ok;
        r_down_ok  <= n_down_ok;
        r_down     <= n_down;
        r_ctr      <= n_ctr;
        r_up       <= n_up;
        r_left     <= n_left;
        r_right    <= n_right;
        r_hold_row <= n_hold_row;
        r_hold_col <= n_hold_col;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_last <= n_out_last;
    end

    // A run never ends with a peak still held
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glpf_pkg::BK_IDLE) |-> !r_hold_valid)
        else $error("peak still held while back end idle");

    // Flush decisions only come from a frame-end command
    a_flush_on_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_flush && r_state != glpf_pkg::BK_IDLE) |-> r_cmd.frame_end)
        else $error("row flush without frame end");

    // Decided column stays inside the grid
    a_dec_col_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == glpf_pkg::BK_READ) |-> (CSZ_W'(r_dec_col) < i_cols_eff))
        else $error("decided column outside grid");
endmodule

// ----- src/grid_local_peak_finder.sv -----
// grid_local_peak_finder: top level; front end, command queue, row store RAM
// and back end. Uses glpf_pkg, glpf_pixel_if, glpf_peak_if and all glpf_* modules.
//
// Usage:
//   i_pix carries signed pixels of a grid_rows x grid_cols grid in raster order.
//   o_peak returns (peak_row, peak_col) of every pixel that is >= each of its
//   in-grid up/down/left/right neighbors, in raster order; last_of_run marks
//   the last word caused by one pixel. Pixels that decide nothing give no word.
//   Configuration: i_cfg_wr_en with i_cfg_index 0 (grid_rows) or 1 (grid_cols)
//   writes a size and restarts the frame; 0 acts as 1, sizes above the maximum
//   act as the maximum. Write only while the block is idle.
//   Throughput: the front end takes one pixel per cycle while the 4-entry
//   command queue has room. Each pixel from row 1 on decides the pixel above it
//   in the back end (queue pop, four reads of the pixel and its up, left and
//   right neighbors through the single read port of the row store, one wait,
//   one compare, one release); row 0 pixels are only popped. The frame's last
//   pixel also decides each pixel of the last row, column by column. At each
//   row change and after the last pixel the front end waits for the back end
//   and the queue to drain.
//   Reset: grid 16 x 16, frame position (0,0), no word pending; the row store
//   needs no clearing. A stalled o_peak holds its word; the back end then
//   stops and the queue fills before i_pix stalls.
module grid_local_peak_finder #(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int PIXEL_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [glpf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [glpf_pkg::CFG_W-1:0]     i_cfg_wdata,
    glpf_pixel_if.sink                     i_pix,
    glpf_peak_if.source                    o_peak
);
    localparam int ROW_W       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CSZ_W       = $clog2(MAX_COLS + 1);
    localparam int STORE_DEPTH = 3 * MAX_COLS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CMD_W       = ROW_W + COL_W + glpf_pkg::SLOT_W + PIXEL_BITS + 1;
    localparam int QUEUE_DEPTH = 4;

    logic                  w_q_push, w_q_pop, w_q_full, w_q_empty, w_busy;
    logic [CMD_W-1:0]      w_q_in, w_q_out;
    logic                  w_ram_we;
    logic [ADDR_W-1:0]     w_ram_waddr, w_ram_raddr;
    logic [PIXEL_BITS-1:0] w_ram_wdata, w_ram_rdata;
    logic [CSZ_W-1:0]      w_cols_eff;
    logic                  w_outstanding;

    glpf_front #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .ROW_W      (ROW_W),
        .COL_W      (COL_W),
        .CSZ_W      (CSZ_W),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .pix         (i_pix),
        .i_busy      (w_outstanding),
        .i_q_full    (w_q_full),
        .o_q_push    (w_q_push),
        .o_q_cmd     (w_q_in),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_cols_eff  (w_cols_eff)
    );

    glpf_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    glpf_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    glpf_back #(
        .MAX_ROWS   (MAX_ROWS),
        .MAX_COLS   (MAX_COLS),
        .PIXEL_BITS (PIXEL_BITS),
        .ROW_W      (ROW_W),
        .COL_W      (COL_W),
        .CSZ_W      (CSZ_W),
        .ADDR_W     (ADDR_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_cmd     (w_q_out),
        .o_q_pop     (w_q_pop),
        .i_cols_eff  (w_cols_eff),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata),
        .o_busy      (w_busy),
        .peak        (o_peak)
    );

    // Outstanding work covers queued commands too
    assign w_outstanding = w_busy || !w_q_empty;

    a_no_write_during_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ram_we && w_busy) |-> !u_back.r_in_flush)
        else $error("row store written while last row is being flushed");
endmodule
